FILE: rtl/qbls_pkg.sv
// Shared types, mode codes and segment fonts for the quiz buzzer lockout scorer.
// No dependencies; used by qbls_display and quiz_buzzer_lockout_scorer_top.
`timescale 1ns / 1ps
`default_nettype none

package qbls_pkg;

    localparam int NUM_PLAYERS = 3;
    localparam logic [3:0] SCORE_MAX = 4'd9;
    localparam logic [NUM_PLAYERS-1:0] ALL_ELIGIBLE = '1;

    // judge button positions in the judge word
    localparam int JUDGE_ARM     = 0;
    localparam int JUDGE_CORRECT = 1;
    localparam int JUDGE_WRONG   = 2;

    // external mode codes
    localparam logic [1:0] MODE_CODE_SCORES  = 2'd0;
    localparam logic [1:0] MODE_CODE_ARMED   = 2'd1;
    localparam logic [1:0] MODE_CODE_ANSWER  = 2'd2;
    localparam logic [1:0] MODE_CODE_WRONG   = 2'd3;

    // one-hot controller state
    typedef enum logic [3:0] {
        MODE_SCORES = 4'b0001,
        MODE_ARMED  = 4'b0010,
        MODE_ANSWER = 4'b0100,
        MODE_WRONG  = 4'b1000
    } mode_t;

    // controller state seen by the display decoder
    typedef struct packed {
        mode_t                       mode;
        logic [1:0]                  player;
        logic [NUM_PLAYERS-1:0][3:0] scores;
    } disp_state_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        case (m)
            MODE_SCORES: c = MODE_CODE_SCORES;
            MODE_ARMED:  c = MODE_CODE_ARMED;
            MODE_ANSWER: c = MODE_CODE_ANSWER;
            MODE_WRONG:  c = MODE_CODE_WRONG;
            default:     c = MODE_CODE_SCORES;
        endcase
        return c;
    endfunction

    // decimal digit font, bit0 segment a .. bit6 segment g; blank above 9
    function automatic logic [6:0] digit_font(input logic [3:0] v);
        logic [6:0] s;
        case (v)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    // contestant letters a, b, c
    function automatic logic [6:0] letter_font(input logic [1:0] i);
        logic [6:0] s;
        case (i)
            2'd0:    s = 7'h5F;
            2'd1:    s = 7'h7C;
            2'd2:    s = 7'h39;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/qbls_display.sv
// Segment decoder: turns the controller state into three 7-segment words.
// Depends on qbls_pkg for the state struct and the fonts.
`timescale 1ns / 1ps
`default_nettype none

module qbls_display
    import qbls_pkg::*;
(
    input  disp_state_t                 disp,
    output logic [NUM_PLAYERS-1:0][6:0] seg
);

    // per-digit pattern chosen by mode
    always_comb
    begin
        for (int i = 0; i < NUM_PLAYERS; i++)
        begin
            logic me;
            logic [6:0] num_w;
            logic [6:0] let_w;
            me    = (disp.player == 2'(i));
            num_w = digit_font(disp.scores[i]);
            let_w = letter_font(2'(i));
            case (disp.mode)
                MODE_SCORES: seg[i] = num_w;
                MODE_ARMED:  seg[i] = let_w;
                MODE_ANSWER: seg[i] = me ? let_w : 7'd0;
                MODE_WRONG:  seg[i] = me ? num_w : let_w;
                default:     seg[i] = 7'd0;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/quiz_buzzer_lockout_scorer_top.sv
// Quiz buzzer with first-press lockout, judge buttons and per-contestant scores.
// Result: the result word of an accepted button word is registered and shows the state before that word acts.
// Throughput: one word per cycle while out_stall is low; the output register is refilled as it drains.
// Reset: mode shows scores, scores zero, all contestants eligible, nothing pending.
// Depends on qbls_pkg and qbls_display.
`timescale 1ns / 1ps
`default_nettype none

module quiz_buzzer_lockout_scorer_top
    import qbls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] contestant_levels,
    input  logic [2:0] judge_levels,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] segments_digit0,
    output logic [6:0] segments_digit1,
    output logic [6:0] segments_digit2,
    output logic [1:0] mode_now,
    output logic [1:0] chosen_player,
    output logic [3:0] score_zero,
    output logic [3:0] score_one,
    output logic [3:0] score_two,
    output logic       answer_pending
);

    // controller state
    mode_t                       mode_reg,    mode_next;
    logic [1:0]                  player_reg,  player_next;
    logic [NUM_PLAYERS-1:0][3:0] scores_reg,  scores_next;
    logic [NUM_PLAYERS-1:0]      elig_reg,    elig_next;
    logic                        pend_reg,    pend_next;
    logic [2:0]                  prev_judge_reg;

    // result register
    logic                        out_valid_reg;
    logic [NUM_PLAYERS-1:0][6:0] seg_reg;
    logic [1:0]                  mode_out_reg;
    logic [1:0]                  player_out_reg;
    logic [NUM_PLAYERS-1:0][3:0] scores_out_reg;
    logic                        pend_out_reg;

    logic                        in_accept;
    disp_state_t                 disp;
    logic [NUM_PLAYERS-1:0][6:0] seg_now;
    logic [NUM_PLAYERS-1:0]      press;
    logic [2:0]                  falls;

    // handshake: accept while the result slot is empty or draining
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // display of the state before this word
    assign disp.mode   = mode_reg;
    assign disp.player = player_reg;
    assign disp.scores = scores_reg;

    qbls_display u_display (
        .disp (disp),
        .seg  (seg_now)
    );

    // next-state: lock, then arm, correct, wrong in that order
    always_comb
    begin
        mode_next   = mode_reg;
        player_next = player_reg;
        scores_next = scores_reg;
        elig_next   = elig_reg;
        pend_next   = pend_reg;

        press = ~contestant_levels & elig_reg;
        falls = ~judge_levels & prev_judge_reg;

        // lowest-indexed eligible press wins in an open mode
        if ((mode_reg == MODE_ARMED || mode_reg == MODE_WRONG) && press != '0)
        begin
            pend_next   = 1'b1;
            mode_next   = MODE_ANSWER;
            player_next = press[0] ? 2'd0 : (press[1] ? 2'd1 : 2'd2);
        end

        if (falls[JUDGE_ARM] && !pend_next && elig_reg == ALL_ELIGIBLE)
        begin
            mode_next = MODE_ARMED;
        end

        if (falls[JUDGE_CORRECT] && pend_next)
        begin
            for (int i = 0; i < NUM_PLAYERS; i++)
            begin
                if (player_next == 2'(i) && scores_reg[i] < SCORE_MAX)
                begin
                    scores_next[i] = scores_reg[i] + 4'd1;
                end
            end
            mode_next = MODE_SCORES;
            elig_next = ALL_ELIGIBLE;
            pend_next = 1'b0;
        end

        if (falls[JUDGE_WRONG] && pend_next)
        begin
            for (int i = 0; i < NUM_PLAYERS; i++)
            begin
                if (player_next == 2'(i))
                begin
                    if (scores_next[i] != 4'd0)
                    begin
                        scores_next[i] = scores_next[i] - 4'd1;
                    end
                    elig_next[i] = 1'b0;
                end
            end
            mode_next = MODE_WRONG;
            pend_next = 1'b0;
        end
    end

    // controller state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SCORES;
            player_reg     <= 2'd0;
            scores_reg     <= '0;
            elig_reg       <= ALL_ELIGIBLE;
            pend_reg       <= 1'b0;
            prev_judge_reg <= 3'b000;
        end
        else if (in_accept)
        begin
            mode_reg       <= mode_next;
            player_reg     <= player_next;
            scores_reg     <= scores_next;
            elig_reg       <= elig_next;
            pend_reg       <= pend_next;
            prev_judge_reg <= judge_levels;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            seg_reg        <= seg_now;
            mode_out_reg   <= mode_code(mode_reg);
            player_out_reg <= player_reg;
            scores_out_reg <= scores_reg;
            pend_out_reg   <= pend_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign segments_digit0 = seg_reg[0];
    assign segments_digit1 = seg_reg[1];
    assign segments_digit2 = seg_reg[2];
    assign mode_now        = mode_out_reg;
    assign chosen_player   = player_out_reg;
    assign score_zero      = scores_out_reg[0];
    assign score_one       = scores_out_reg[1];
    assign score_two       = scores_out_reg[2];
    assign answer_pending  = pend_out_reg;

    // pending answer exactly while in answering mode
    a_pend_mode: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == (mode_reg == MODE_ANSWER))
        else $error("pending flag out of step with mode");

    // scores never pass the ceiling
    a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
        scores_reg[0] <= SCORE_MAX && scores_reg[1] <= SCORE_MAX
        && scores_reg[2] <= SCORE_MAX)
        else $error("score above maximum");

    // locked player is always a real contestant
    a_player_range: assert property (@(posedge clk) disable iff (!rst_n)
        player_reg != 2'd3)
        else $error("player index out of range");

    // score display and armed mode only with everyone eligible
    a_elig_full: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SCORES || mode_reg == MODE_ARMED) |-> elig_reg == ALL_ELIGIBLE)
        else $error("contestant disabled outside wrong-answer flow");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for quiz_buzzer_lockout_scorer_top: opening rows, random words, closing rows.
// Depends on qbls_pkg and the RTL of quiz_buzzer_lockout_scorer_top; checks against a local predictor.
`timescale 1ns / 1ps

module testbench;
    import qbls_pkg::*;

    localparam int RANDOM_WORDS = 1600;
    localparam int HEAD_ROWS    = 13;
    localparam int IDLE_PCT     = 15;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    // segment patterns, bit0 segment a .. bit6 segment g; blank above 9
    localparam logic [15:0][6:0] SEG_DIGIT = {{6{7'h00}}, 7'h6F, 7'h7F, 7'h07, 7'h7D,
                                              7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};
    localparam logic [2:0][6:0]  SEG_LETTER = {7'h39, 7'h7C, 7'h5F};

    // judge words, active low
    localparam logic [2:0] JUDGE_IDLE    = 3'b111;
    localparam logic [2:0] JUDGE_ARM_LO  = 3'b110;
    localparam logic [2:0] JUDGE_OK_LO   = 3'b101;
    localparam logic [2:0] JUDGE_BAD_LO  = 3'b011;
    localparam logic [2:0] JUDGE_BOTH_LO = 3'b001;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [1:0]                  player;
        logic [NUM_PLAYERS-1:0][3:0] scores;
        logic [2:0]                  eligible;
        logic                        pending;
        logic [2:0]                  prev_judge;
    } buzzer_state_t;

    typedef struct packed {
        logic [2:0][6:0] seg;
        logic [1:0]      mode;
        logic [1:0]      player;
        logic [2:0][3:0] scores;
        logic            pending;
    } buzzer_word_t;

    typedef struct packed {
        logic [2:0]   buttons;
        logic [2:0]   judge;
        logic         has_ref;
        buzzer_word_t ref_word;
    } stim_row_t;

    // display after reset and in armed mode, read straight off the spec
    localparam buzzer_word_t SHOW_RESET = '{seg: {7'h3F, 7'h3F, 7'h3F},
                                           mode: MODE_CODE_SCORES, player: 2'd0,
                                           scores: '0, pending: 1'b0};
    localparam buzzer_word_t SHOW_ARMED = '{seg: {7'h39, 7'h7C, 7'h5F},
                                           mode: MODE_CODE_ARMED, player: 2'd0,
                                           scores: '0, pending: 1'b0};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] contestant_levels;
    logic [2:0] judge_levels;
    logic       out_valid;
    logic       out_stall;
    logic [6:0] segments_digit0;
    logic [6:0] segments_digit1;
    logic [6:0] segments_digit2;
    logic [1:0] mode_now;
    logic [1:0] chosen_player;
    logic [3:0] score_zero;
    logic [3:0] score_one;
    logic [3:0] score_two;
    logic       answer_pending;

    buzzer_state_t   buzzer_model;
    buzzer_word_t    expected_words[$];
    buzzer_word_t    want_word;
    stim_row_t       directed_rows[$];
    logic            row_has_ref;
    buzzer_word_t    row_ref;
    logic            in_took;
    logic            quiet;
    int unsigned     mismatch_count;
    int unsigned     cycle_count;

    quiz_buzzer_lockout_scorer_top i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .contestant_levels (contestant_levels),
        .judge_levels      (judge_levels),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .segments_digit0   (segments_digit0),
        .segments_digit1   (segments_digit1),
        .segments_digit2   (segments_digit2),
        .mode_now          (mode_now),
        .chosen_player     (chosen_player),
        .score_zero        (score_zero),
        .score_one         (score_one),
        .score_two         (score_two),
        .answer_pending    (answer_pending)
    );

    // one step of the controller: lockout, then arm, correct, wrong
    function automatic buzzer_state_t buzzer_advance(input buzzer_state_t s,
                                                     input logic [2:0] buttons,
                                                     input logic [2:0] judge);
        logic [2:0] falls;
        falls = ~judge & s.prev_judge;
        for (int i = 0; i < NUM_PLAYERS; i++)
        begin
            if (!buttons[i] && s.eligible[i]
                && (s.mode == MODE_CODE_ARMED || s.mode == MODE_CODE_WRONG))
            begin
                s.pending = 1'b1;
                s.player  = 2'(i);
                s.mode    = MODE_CODE_ANSWER;
            end
        end
        if (falls[JUDGE_ARM] && !s.pending && s.eligible == ALL_ELIGIBLE)
            s.mode = MODE_CODE_ARMED;
        if (falls[JUDGE_CORRECT] && s.pending)
        begin
            if (s.player < NUM_PLAYERS && s.scores[s.player] < SCORE_MAX)
                s.scores[s.player] = s.scores[s.player] + 4'd1;
            s.mode     = MODE_CODE_SCORES;
            s.eligible = ALL_ELIGIBLE;
            s.pending  = 1'b0;
        end
        if (falls[JUDGE_WRONG] && s.pending)
        begin
            if (s.player < NUM_PLAYERS)
            begin
                if (s.scores[s.player] > 4'd0)
                    s.scores[s.player] = s.scores[s.player] - 4'd1;
                s.eligible = s.eligible & ~(3'b001 << s.player);
            end
            s.mode    = MODE_CODE_WRONG;
            s.pending = 1'b0;
        end
        s.prev_judge = judge;
        return s;
    endfunction

    // result word shown for a state, before the step acts
    function automatic buzzer_word_t buzzer_display(input buzzer_state_t s);
        buzzer_word_t w;
        logic         me;
        for (int i = 0; i < NUM_PLAYERS; i++)
        begin
            me = (s.player == 2'(i));
            case (s.mode)
                MODE_CODE_SCORES: w.seg[i] = SEG_DIGIT[s.scores[i]];
                MODE_CODE_ARMED:  w.seg[i] = SEG_LETTER[i];
                MODE_CODE_ANSWER: w.seg[i] = me ? SEG_LETTER[i] : 7'h00;
                default:          w.seg[i] = me ? SEG_DIGIT[s.scores[i]] : SEG_LETTER[i];
            endcase
        end
        w.mode    = s.mode;
        w.player  = s.player;
        w.scores  = s.scores;
        w.pending = s.pending;
        return w;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result check first, then prediction of the accepted button word
    always @(posedge clk)
    begin
        in_took = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with no expectation waiting");
                mismatch_count++;
            end
            else
            begin
                want_word = expected_words.pop_front();
                check_field("segments_digit0", want_word.seg[0], segments_digit0);
                check_field("segments_digit1", want_word.seg[1], segments_digit1);
                check_field("segments_digit2", want_word.seg[2], segments_digit2);
                check_field("mode_now", want_word.mode, mode_now);
                check_field("chosen_player", want_word.player, chosen_player);
                check_field("score_zero", want_word.scores[0], score_zero);
                check_field("score_one", want_word.scores[1], score_one);
                check_field("score_two", want_word.scores[2], score_two);
                check_field("answer_pending", want_word.pending, answer_pending);
            end
        end
        if (in_took)
        begin
            expected_words.push_back(row_has_ref ? row_ref : buzzer_display(buzzer_model));
            buzzer_model = buzzer_advance(buzzer_model, contestant_levels, judge_levels);
        end
    end

    // result side stall
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // present one button word, with random idle cycles ahead of it
    task automatic send_word(input logic [2:0] buttons, input logic [2:0] judge,
                             input logic has_ref, input buzzer_word_t ref_word);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        contestant_levels <= buttons;
        judge_levels      <= judge;
        row_has_ref       <= has_ref;
        row_ref           <= ref_word;
        do
            @(negedge clk);
        while (!in_took);
    endtask

    task automatic add_row(input logic [2:0] buttons, input logic [2:0] judge,
                           input logic has_ref, input buzzer_word_t ref_word);
        stim_row_t r;
        r.buttons  = buttons;
        r.judge    = judge;
        r.has_ref  = has_ref;
        r.ref_word = ref_word;
        directed_rows.push_back(r);
    endtask

    // mostly well-formed quiz play driven off the predicted state, some noise
    task automatic random_word(output logic [2:0] buttons, output logic [2:0] judge);
        buzzer_state_t s;
        buzzer_state_t peek;
        s       = buzzer_model;
        buttons = 3'($urandom_range(7));
        judge   = JUDGE_IDLE;
        if ($urandom_range(99) < 15)
            judge = 3'($urandom_range(7));
        else if (s.prev_judge != JUDGE_IDLE && $urandom_range(3) != 0)
            judge = JUDGE_IDLE;
        else
        begin
            case (s.mode)
                MODE_CODE_SCORES:
                    judge = JUDGE_ARM_LO;
                MODE_CODE_ANSWER:
                begin
                    if ($urandom_range(9) == 0)
                        judge = JUDGE_BOTH_LO;
                    else
                        judge = ($urandom_range(99) < 60) ? JUDGE_OK_LO : JUDGE_BAD_LO;
                end
                default:
                begin
                    buttons = ($urandom_range(4) == 0) ? 3'b111 : 3'($urandom_range(6));
                    if ($urandom_range(99) < 25)
                        judge = 3'($urandom_range(7));
                end
            endcase
        end
        // keep at least one contestant eligible, the all-disabled lock is tested at the end
        peek = buzzer_advance(s, buttons, judge);
        if (peek.eligible == 3'b000)
            judge[JUDGE_WRONG] = 1'b1;
    endtask

    // stimulus
    initial
    begin
        logic [2:0] buttons;
        logic [2:0] judge;

        rst_n             = 1'b0;
        in_valid          = 1'b0;
        contestant_levels = 3'b111;
        judge_levels      = 3'b000;
        row_has_ref       = 1'b0;
        row_ref           = '0;
        in_took           = 1'b0;
        quiet             = 1'b0;
        mismatch_count    = 0;
        buzzer_model      = '{mode: MODE_CODE_SCORES, player: 2'd0, scores: '0,
                              eligible: ALL_ELIGIBLE, pending: 1'b0, prev_judge: 3'b000};

        // opening rows: judge held low out of reset, arm, lock and judge each way
        add_row(3'b111, 3'b000,        1'b1, SHOW_RESET);    // held low at reset: no edge
        add_row(3'b111, JUDGE_IDLE,    1'b1, SHOW_RESET);
        add_row(3'b000, JUDGE_ARM_LO,  1'b1, SHOW_RESET);    // presses ignored while scores show
        add_row(3'b111, JUDGE_IDLE,    1'b1, SHOW_ARMED);
        add_row(3'b011, JUDGE_IDLE,    1'b1, SHOW_ARMED);    // contestant 2 locks in
        add_row(3'b111, JUDGE_OK_LO,   1'b0, '0);
        add_row(3'b111, JUDGE_IDLE,    1'b0, '0);
        add_row(3'b111, JUDGE_ARM_LO,  1'b0, '0);
        add_row(3'b000, JUDGE_BAD_LO,  1'b0, '0);            // lock and wrong in one word, floor at 0
        add_row(3'b110, JUDGE_IDLE,    1'b0, '0);            // disabled contestant presses
        add_row(3'b101, JUDGE_IDLE,    1'b0, '0);
        add_row(3'b111, JUDGE_BOTH_LO, 1'b0, '0);            // correct wins, wrong ignored
        add_row(3'b111, JUDGE_IDLE,    1'b0, '0);
        // closing rows: back to armed from any state, then disable everyone
        add_row(3'b111, JUDGE_IDLE,    1'b0, '0);
        add_row(3'b000, JUDGE_IDLE,    1'b0, '0);
        add_row(3'b111, JUDGE_OK_LO,   1'b0, '0);
        add_row(3'b111, JUDGE_IDLE,    1'b0, '0);
        add_row(3'b111, JUDGE_ARM_LO,  1'b0, '0);
        add_row(3'b111, JUDGE_IDLE,    1'b0, '0);
        add_row(3'b110, JUDGE_BAD_LO,  1'b0, '0);
        add_row(3'b101, JUDGE_IDLE,    1'b0, '0);
        add_row(3'b111, JUDGE_BAD_LO,  1'b0, '0);
        add_row(3'b011, JUDGE_IDLE,    1'b0, '0);
        add_row(3'b111, JUDGE_BAD_LO,  1'b0, '0);            // last eligible one gone
        add_row(3'b000, JUDGE_ARM_LO,  1'b0, '0);            // arm refused
        add_row(3'b000, JUDGE_IDLE,    1'b0, '0);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int n = 0; n < HEAD_ROWS; n++)
            send_word(directed_rows[n].buttons, directed_rows[n].judge,
                      directed_rows[n].has_ref, directed_rows[n].ref_word);

        // hold the sender until the directed results are all back
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_words.size() != 0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            quiet = (n >= 300 && n < 600);
            if (n == 800)
            begin
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (expected_words.size() != 0);
            end
            random_word(buttons, judge);
            send_word(buttons, judge, 1'b0, '0);
        end
        quiet = 1'b0;

        for (int n = HEAD_ROWS; n < directed_rows.size(); n++)
            send_word(directed_rows[n].buttons, directed_rows[n].judge,
                      directed_rows[n].has_ref, directed_rows[n].ref_word);

        // drain
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
